/* rtl/frequent_itemset_support_count_assert.svh */
// Assertion macros shared by the frequent itemset support counter modules.
`ifndef FREQUENT_ITEMSET_SUPPORT_COUNT_ASSERT_SVH
`define FREQUENT_ITEMSET_SUPPORT_COUNT_ASSERT_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define FISC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define FISC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Invariant that holds on every clock edge outside of reset.
`define FISC_ASSERT_ALW(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

`endif

/* rtl/fisc_pkg.sv */
// Shared constants, types and tables of the frequent itemset support counter.
`default_nettype none

package fisc_pkg;

    // Fixed sizes of the block.
    localparam int ITEMS       = 6;
    localparam int MASK_W      = ITEMS;
    localparam int SETS        = (1 << ITEMS) - 1;
    localparam int COUNT_WIDTH = 16;
    localparam int BP_W        = 14;
    localparam int IC_W        = 3;
    localparam int PROD_W      = COUNT_WIDTH + BP_W;
    localparam int BP_SCALE    = 10000;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BP_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUPPORT = 1'b1;

    // Input beat kinds carried on s_tuser.
    localparam logic MODE_COUNT  = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [IC_W-1:0] ITEM_COUNT_RST  = 3'd6;
    localparam logic [BP_W-1:0] MIN_SUPPORT_RST = 14'd5000;

    // Report order: by itemset size, then lexicographic order of item indices.
    localparam logic [MASK_W-1:0] ORDER_MASK [SETS] = '{
        6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20,
        6'h03, 6'h05, 6'h09, 6'h11, 6'h21, 6'h06, 6'h0A, 6'h12, 6'h22,
        6'h0C, 6'h14, 6'h24, 6'h18, 6'h28, 6'h30,
        6'h07, 6'h0B, 6'h13, 6'h23, 6'h0D, 6'h15, 6'h25, 6'h19, 6'h29,
        6'h31, 6'h0E, 6'h16, 6'h26, 6'h1A, 6'h2A, 6'h32, 6'h1C, 6'h2C,
        6'h34, 6'h38,
        6'h0F, 6'h17, 6'h27, 6'h1B, 6'h2B, 6'h33, 6'h1D, 6'h2D, 6'h35,
        6'h39, 6'h1E, 6'h2E, 6'h36, 6'h3A, 6'h3C,
        6'h1F, 6'h2F, 6'h37, 6'h3B, 6'h3D, 6'h3E,
        6'h3F
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take the input beat
        logic cnt_rd;    // read the next counter of a count walk
        logic rpt_rd;    // read the counter at the current report position
        logic rpt_skip;  // step past a report position outside the items in use
        logic rpt_eval;  // judge the counter read and step on
        logic flush;     // send the final result and clear the counts
    } fisc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic total_zero;
        logic cw_last;
        logic p_in_range;
        logic p_last;
        logic qual;
        logic pend_valid;
        logic out_free;
    } fisc_sts_t;

    // Mask of the items in use; zero counts as one item, large values as all.
    function automatic logic [MASK_W-1:0] full_mask(input logic [IC_W-1:0] ic);
        logic [MASK_W-1:0] m;
        case (ic)
            3'd0, 3'd1: m = 6'h01;
            3'd2:       m = 6'h03;
            3'd3:       m = 6'h07;
            3'd4:       m = 6'h0F;
            3'd5:       m = 6'h1F;
            default:    m = 6'h3F;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/fisc_ctrl.sv */
// Controller state machine that sequences count walks and report scans.
`default_nettype none

`include "frequent_itemset_support_count_assert.svh"

module fisc_ctrl import fisc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    input  wire logic s_tuser,
    output logic      s_tready,
    output fisc_cmd_t cmd,
    input  fisc_sts_t sts
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CNT    = 6'b000010,
        ST_CNT_WB = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_EVAL   = 6'b010000,
        ST_FLUSH  = 6'b100000
    } fisc_state_t;

    fisc_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tuser == MODE_COUNT) begin
                        state_next = ST_CNT;
                    end else if (sts.total_zero) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CNT: begin
                cmd.cnt_rd = 1'b1;
                if (sts.cw_last) begin
                    state_next = ST_CNT_WB;
                end
            end
            ST_CNT_WB: begin
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (sts.p_in_range) begin
                    cmd.rpt_rd = 1'b1;
                    state_next = ST_EVAL;
                end else begin
                    cmd.rpt_skip = 1'b1;
                    if (sts.p_last) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_EVAL: begin
                // A hit that displaces a pending result needs a free output slot.
                if (!(sts.qual && sts.pend_valid) || sts.out_free) begin
                    cmd.rpt_eval = 1'b1;
                    state_next   = sts.p_last ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    `FISC_ASSERT_NXT(a_count_starts_walk, cmd.load && s_tuser == MODE_COUNT, state_reg == ST_CNT, "count beat did not start a counter walk")
    `FISC_ASSERT_NXT(a_walk_end_writes_back, cmd.cnt_rd && sts.cw_last, state_reg == ST_CNT_WB, "counter walk did not finish with a write-back cycle")
    `FISC_ASSERT_ALW(a_one_command, $onehot0({cmd.load, cmd.cnt_rd, cmd.rpt_rd, cmd.rpt_skip, cmd.rpt_eval, cmd.flush}), "more than one datapath command at once")

endmodule

`default_nettype wire

/* rtl/fisc_dpath.sv */
// Datapath: counter memory, totals, threshold compare and result register.
`default_nettype none

`include "frequent_itemset_support_count_assert.svh"

module fisc_dpath import fisc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration writes.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Input beat payload.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [M_TUSER_W-1:0]       m_tuser,
    output logic                       m_tlast,
    // Controller link.
    input  fisc_cmd_t                  cmd,
    output fisc_sts_t                  sts
);

    // Configuration registers.
    logic [IC_W-1:0] item_count_reg;
    logic [BP_W-1:0] min_bp_reg;

    // Transaction state.
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic                   sat_reg, sat_next;
    logic [MASK_W-1:0]      t_reg;
    logic [PROD_W-1:0]      need_reg;

    // Walk position for counting and for reporting.
    logic [MASK_W-1:0]      cw_reg;
    logic [MASK_W-1:0]      p_reg;

    // Counter memory, its valid bits and its registered read port.
    logic [COUNT_WIDTH-1:0] cnt_mem [SETS];
    logic [SETS-1:0]        vbits_reg;
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic                   rvalid_reg;
    logic [MASK_W-1:0]      rd_addr;

    // Write-back stage of the count walk.
    logic                   wr_go_reg;
    logic [MASK_W-1:0]      wr_m_reg;
    logic [MASK_W-1:0]      wr_addr;
    logic                   mem_we;

    // Pending hit that waits to learn whether it is the last one.
    logic                   pend_valid_reg;
    logic [MASK_W-1:0]      pend_mask_reg;
    logic [COUNT_WIDTH-1:0] pend_cnt_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [MASK_W-1:0]      out_mask_reg;
    logic [COUNT_WIDTH-1:0] out_cnt_reg;
    logic [COUNT_WIDTH-1:0] out_total_reg;
    logic                   out_freq_reg;
    logic                   out_ovf_reg;
    logic                   out_last_reg;

    logic [MASK_W-1:0]      full;
    logic [MASK_W-1:0]      order_m;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic                   cur_at_max;
    logic [COUNT_WIDTH-1:0] inc_val;
    logic [PROD_W-1:0]      scaled;
    logic                   qual;
    logic                   out_free;
    logic                   push_pend;
    logic                   push_marker;

    assign full    = full_mask(item_count_reg);
    assign order_m = ORDER_MASK[p_reg];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= ITEM_COUNT_RST;
            min_bp_reg     <= MIN_SUPPORT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ITEM_COUNT:  item_count_reg <= cfg_wr_data[IC_W-1:0];
                CFG_MIN_SUPPORT: min_bp_reg     <= cfg_wr_data;
                default:         item_count_reg <= item_count_reg;
            endcase
        end
    end

    // Counter value read back; an entry never written since the last clear is zero.
    assign cur_cnt    = rvalid_reg ? rdata_reg : '0;
    assign cur_at_max = (cur_cnt == COUNT_MAX);
    assign inc_val    = cur_at_max ? cur_cnt : cur_cnt + 1'b1;

    // Write back only itemsets that the transaction contains.
    assign wr_addr = wr_m_reg - 1'b1;
    assign mem_we  = wr_go_reg && ((t_reg & wr_m_reg) == wr_m_reg);

    // One read port serves the count walk and the report scan.
    assign rd_addr = cmd.cnt_rd ? (cw_reg - 1'b1) : (order_m - 1'b1);

    // Counter memory.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cnt_mem[wr_addr] <= inc_val;
        end
        rdata_reg  <= cnt_mem[rd_addr];
        rvalid_reg <= vbits_reg[rd_addr];
    end

    // Valid bits: cleared by reset and at the end of every report.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.flush) begin
            vbits_reg <= '0;
        end else if (mem_we) begin
            vbits_reg[wr_addr] <= 1'b1;
        end
    end

    // Threshold compare: count * 10000 against min_support_bp * total.
    assign scaled = PROD_W'(cur_cnt) * PROD_W'(BP_SCALE);
    assign qual   = (scaled >= need_reg);

    // Total and saturation flag.
    always_comb begin
        total_next = total_reg;
        sat_next   = sat_reg;
        if (cmd.flush) begin
            total_next = '0;
            sat_next   = 1'b0;
        end else begin
            if (cmd.load && s_tuser == MODE_COUNT) begin
                if (total_reg == COUNT_MAX) begin
                    sat_next = 1'b1;
                end else begin
                    total_next = total_reg + 1'b1;
                end
            end
            if (mem_we && cur_at_max) begin
                sat_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            total_reg <= total_next;
            sat_reg   <= sat_next;
        end
    end

    // Beat capture and walk positions.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t_reg    <= s_tdata[MASK_W-1:0] & full;
            need_reg <= PROD_W'(min_bp_reg) * PROD_W'(total_reg);
            cw_reg   <= MASK_W'(1);
            p_reg    <= '0;
        end else begin
            if (cmd.cnt_rd) begin
                cw_reg <= cw_reg + 1'b1;
            end
            if (cmd.rpt_skip || cmd.rpt_eval) begin
                p_reg <= p_reg + 1'b1;
            end
        end
        wr_m_reg <= cw_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_go_reg <= 1'b0;
        end else begin
            wr_go_reg <= cmd.cnt_rd;
        end
    end

    // Result hand-off: a hit pushes the previous pending one; the flush
    // pushes the final pending hit, or the marker when there is none.
    assign out_free    = !out_valid_reg || m_tready;
    assign push_pend   = pend_valid_reg && ((cmd.rpt_eval && qual) || cmd.flush);
    assign push_marker = cmd.flush && !pend_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.flush) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.rpt_eval && qual) begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rpt_eval && qual) begin
            pend_mask_reg <= order_m;
            pend_cnt_reg  <= cur_cnt;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push_pend || push_marker) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_pend || push_marker) begin
            out_mask_reg  <= push_marker ? '0 : pend_mask_reg;
            out_cnt_reg   <= push_marker ? '0 : pend_cnt_reg;
            out_total_reg <= total_reg;
            out_freq_reg  <= !push_marker;
            out_ovf_reg   <= sat_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - MASK_W - 2*COUNT_WIDTH){1'b0}},
                       out_total_reg, out_cnt_reg, out_mask_reg};
    assign m_tuser  = {out_ovf_reg, out_freq_reg};
    assign m_tlast  = out_last_reg;

    // Status to the controller.
    always_comb begin
        sts            = '0;
        sts.total_zero = (total_reg == '0);
        sts.cw_last    = (cw_reg == full);
        sts.p_in_range = ((order_m & ~full) == '0);
        sts.p_last     = (p_reg == MASK_W'(SETS - 1));
        sts.qual       = qual;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    `FISC_ASSERT_IMP(a_push_needs_slot, push_pend || push_marker, !out_valid_reg || m_tready, "result pushed over a beat not yet taken")
    `FISC_ASSERT_NXT(a_flush_clears, cmd.flush, total_reg == '0 && !sat_reg && !pend_valid_reg, "report end did not clear the counts")
    `FISC_ASSERT_IMP(a_write_in_range, mem_we, (wr_m_reg & ~t_reg) == '0 && wr_m_reg != '0, "counter written for an itemset outside the transaction")

endmodule

`default_nettype wire

/* rtl/frequent_itemset_support_count.sv */
// Top level of the frequent itemset support counter.
//
// Input channel (s_*): one beat per command. s_tuser = 0 counts the
// transaction in s_tdata[5:0]; s_tuser = 1 reports the frequent itemsets
// and clears all counts. s_tready is high only while the block is idle.
// Result channel (m_*): one beat per frequent itemset, ordered by size and
// then by item index; m_tlast marks the final beat of a report. With no
// transactions or no frequent itemset, one marker beat with m_tuser[0] = 0.
// During a count beat the walk reads one counter a cycle through the single
// read port of the counter memory, then writes back. A report steps past each
// itemset outside the items in use, reads and judges each itemset inside
// them, then finishes with a flush; a result leaves after its successor is
// found, the last with the flush.
// Reset clears all counts, the total and the overflow flag and sets
// item_count = 6, min_support_bp = 5000. A stalled receiver holds the
// result register; the scan waits until the next result can be placed.
`default_nettype none

module frequent_itemset_support_count import fisc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [5:0] transaction_bits, [7:6] zero
    input  wire logic                  s_tuser,   // [0] mode
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [5:0] itemset_mask,
                                                  // [21:6] support_count,
                                                  // [37:22] transaction_total,
                                                  // [39:38] zero
    output logic [M_TUSER_W-1:0]       m_tuser,   // [0] frequent, [1] overflow
    output logic                       m_tlast
);

    fisc_cmd_t cmd;
    fisc_sts_t sts;

    // Controller.
    fisc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath.
    fisc_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the frequent itemset support counter.
module tb;
    import fisc_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int COUNT_SETTLE = 72;   // covers the busy time of a count beat
    localparam int FINAL_SETTLE = 140;  // covers a full report walk

    // One expected result beat of a report.
    typedef struct packed {
        logic [MASK_W-1:0]      mask;
        logic [COUNT_WIDTH-1:0] support;
        logic [COUNT_WIDTH-1:0] total;
        logic                   frequent;
        logic                   overflow;
        logic                   last;
    } itemset_result_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata      = '0;
    logic                  s_tuser      = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    // Mirror of the block's counting state and registers.
    logic [COUNT_WIDTH-1:0] support_tbl [1:SETS];
    logic [COUNT_WIDTH-1:0] txn_total  = '0;
    logic                   sat_seen   = 1'b0;
    logic [IC_W-1:0]        cfg_items  = ITEM_COUNT_RST;
    logic [BP_W-1:0]        cfg_min_bp = MIN_SUPPORT_RST;

    itemset_result_t report_rows_q [$];
    itemset_result_t want_row, got_row;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    frequent_itemset_support_count u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),    // [5:0] transaction_bits, [7:6] zero
        .s_tuser      (s_tuser),    // [0] mode
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),    // [5:0] itemset_mask, [21:6] support_count,
                                    // [37:22] transaction_total, [39:38] zero
        .m_tuser      (m_tuser),    // [0] frequent, [1] overflow
        .m_tlast      (m_tlast)
    );

    always #4 aclk = ~aclk;

    initial begin
        for (int i = 1; i <= SETS; i++) begin
            support_tbl[i] = '0;
        end
    end

    // Number of items in use after clamping the register to the legal range.
    function automatic int used_items();
        if (cfg_items == 0) return 1;
        if (cfg_items > ITEMS) return ITEMS;
        return int'(cfg_items);
    endfunction

    // Saturating increment; a counter at its ceiling sets the overflow flag.
    function automatic logic [COUNT_WIDTH-1:0] sat_bump(input logic [COUNT_WIDTH-1:0] v);
        if (v == COUNT_MAX) begin
            sat_seen = 1'b1;
            return v;
        end
        return v + 1'b1;
    endfunction

    // A count beat bumps the total and every itemset contained in the transaction.
    function automatic void count_transaction(input logic [MASK_W-1:0] bits);
        logic [MASK_W-1:0] full;
        logic [MASK_W-1:0] present;
        full      = MASK_W'((1 << used_items()) - 1);
        present   = bits & full;
        txn_total = sat_bump(txn_total);
        for (int m = 1; m <= int'(full); m++) begin
            if ((present & MASK_W'(m)) == MASK_W'(m)) begin
                support_tbl[m] = sat_bump(support_tbl[m]);
            end
        end
    endfunction

    // A report beat queues the frequent itemsets in size order, then in
    // lexicographic order of item indices, and clears the counts.
    function automatic void predict_report();
        itemset_result_t   hits [$];
        itemset_result_t   row;
        logic [MASK_W-1:0] full;
        logic [MASK_W-1:0] m;
        longint            need;
        int                n;
        n    = used_items();
        full = MASK_W'((1 << n) - 1);
        if (txn_total != 0) begin
            need = longint'(cfg_min_bp) * longint'(txn_total);
            for (int k = 1; k <= n; k++) begin
                // Walking mirrored masks downward yields ascending index lists.
                for (int r = int'(full); r >= 1; r--) begin
                    if ($countones(r) == k) begin
                        m = '0;
                        for (int b = 0; b < n; b++) begin
                            if (r[b]) m[n-1-b] = 1'b1;
                        end
                        if (longint'(support_tbl[m]) * 10000 >= need) begin
                            row = '{m, support_tbl[m], txn_total, 1'b1, sat_seen, 1'b0};
                            hits.insert(hits.size(), row);
                        end
                    end
                end
            end
        end
        if (hits.size() == 0) begin
            row = '{'0, '0, txn_total, 1'b0, sat_seen, 1'b1};
            hits.insert(hits.size(), row);
        end
        foreach (hits[i]) begin
            row      = hits[i];
            row.last = (i == hits.size() - 1);
            report_rows_q.insert(report_rows_q.size(), row);
        end
        for (int i = 1; i <= SETS; i++) begin
            support_tbl[i] = '0;
        end
        txn_total = '0;
        sat_seen  = 1'b0;
    endfunction

    // Offer one beat after random gaps and update the prediction on acceptance.
    task automatic send_beat(input logic mode, input logic [MASK_W-1:0] bits);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - MASK_W){1'b0}}, bits};
        do @(posedge aclk); while (!s_tready);
        if (mode == MODE_REPORT) predict_report();
        else count_transaction(bits);
    endtask

    // Stop offering beats, wait for every expected result, then let the block settle.
    task automatic wait_idle(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (report_rows_q.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ITEM_COUNT) cfg_items = val[IC_W-1:0];
        else cfg_min_bp = val[BP_W-1:0];
    endtask

    task automatic set_config(input int items, input int min_bp);
        wait_idle(COUNT_SETTLE);
        write_reg(CFG_ITEM_COUNT, CFG_DATA_W'(items));
        write_reg(CFG_MIN_SUPPORT, CFG_DATA_W'(min_bp));
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
    endtask

    // Check each result beat against the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_row = '{m_tdata[MASK_W-1:0],
                        m_tdata[MASK_W +: COUNT_WIDTH],
                        m_tdata[MASK_W + COUNT_WIDTH +: COUNT_WIDTH],
                        m_tuser[0], m_tuser[1], m_tlast};
            if (report_rows_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none actual %h",
                         $time, got_row);
            end else begin
                want_row = report_rows_q.pop_front();
                if (got_row.mask !== want_row.mask)
                    report_mismatch("itemset_mask", 32'(want_row.mask), 32'(got_row.mask));
                if (got_row.support !== want_row.support)
                    report_mismatch("support_count", 32'(want_row.support),
                                    32'(got_row.support));
                if (got_row.total !== want_row.total)
                    report_mismatch("transaction_total", 32'(want_row.total),
                                    32'(got_row.total));
                if (got_row.frequent !== want_row.frequent)
                    report_mismatch("frequent", 32'(want_row.frequent),
                                    32'(got_row.frequent));
                if (got_row.overflow !== want_row.overflow)
                    report_mismatch("overflow", 32'(want_row.overflow),
                                    32'(got_row.overflow));
                if (got_row.last !== want_row.last)
                    report_mismatch("last", 32'(want_row.last), 32'(got_row.last));
            end
        end
    end

    // Report with no transactions yet, then four count beats and a second report, under the reset configuration.
    task automatic test_empty_report();
        send_beat(MODE_REPORT, '0);
        send_beat(MODE_COUNT, 6'h3F);
        send_beat(MODE_COUNT, 6'h00);
        send_beat(MODE_COUNT, 6'h01);
        send_beat(MODE_COUNT, 6'h2A);
        send_beat(MODE_REPORT, '0);
    endtask

    // Extremes of the registers, clamped item counts and ignored bits.
    task automatic test_directed_cases();
        // Item count zero acts as one item; zero support reports everything in use.
        set_config(0, 0);
        send_beat(MODE_COUNT, 6'h3F);
        send_beat(MODE_COUNT, 6'h02);
        send_beat(MODE_REPORT, 6'h3F);
        // Item count seven acts as six; support above 100 percent finds nothing.
        set_config(7, 16383);
        send_beat(MODE_COUNT, 6'h15);
        send_beat(MODE_REPORT, 6'h2A);
        // Exactly 100 percent, higher transaction bits ignored.
        set_config(3, 10000);
        send_beat(MODE_COUNT, 6'h3F);
        send_beat(MODE_COUNT, 6'h07);
        send_beat(MODE_REPORT, 6'h00);
        // Threshold sits right at two thirds.
        set_config(2, 6667);
        send_beat(MODE_COUNT, 6'h01);
        send_beat(MODE_COUNT, 6'h03);
        send_beat(MODE_COUNT, 6'h02);
        send_beat(MODE_REPORT, 6'h15);
        // All six items at zero support: the longest report.
        set_config(6, 0);
        send_beat(MODE_COUNT, 6'h3F);
        send_beat(MODE_REPORT, 6'h3F);
    endtask

    // Runs of transactions closed by a report, with fresh settings now and then.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int beats);
        logic [MASK_W-1:0] hot;
        int                sent;
        int                run_len;
        int                pick;
        int                min_bp;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        while (sent < beats) begin
            pick = $urandom_range(4);
            case (pick)
                0:       min_bp = 0;
                1:       min_bp = 10000;
                2:       min_bp = $urandom_range(16383, 10001);
                3:       min_bp = $urandom_range(10000, 0);
                default: min_bp = $urandom_range(7000, 3000);
            endcase
            set_config($urandom_range(7, 0), min_bp);
            repeat (4) begin
                run_len = $urandom_range(12, 0);
                hot     = MASK_W'($urandom);
                for (int j = 0; j < run_len; j++) begin
                    if ($urandom_range(1)) send_beat(MODE_COUNT, MASK_W'($urandom));
                    else send_beat(MODE_COUNT, hot | MASK_W'($urandom & $urandom));
                end
                send_beat(MODE_REPORT, MASK_W'($urandom));
                sent += run_len + 1;
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(6, 0);
        @(posedge aclk);
        stall_left = 400;
        repeat (3) begin
            repeat (4) send_beat(MODE_COUNT, MASK_W'($urandom));
            send_beat(MODE_REPORT, MASK_W'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_report();
        test_directed_cases();
        test_random_traffic(9, 54, 120);
        test_random_traffic(54, 9, 120);
        test_random_traffic(0, 0, 120);
        test_backpressure();
        wait_idle(FINAL_SETTLE);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
